// ----- rtl/ssft_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssft_pkg
// Shared types and constants for the sorted style/flag table.
// ----------------------------------------------------------------------------
package ssft_pkg;

  localparam int CAPACITY     = 64;
  localparam int MAX_STYLES   = 32;
  localparam int FLAG_WIDTH   = 32;
  localparam int HANDLE_WIDTH = 32;
  localparam int IDX_W        = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int STYLE_W      = 5;
  localparam int CFG_W        = 6;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_MATCH    = 3'd2;
  localparam logic [2:0] ST_DEFAULT  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_BADSTYLE = 3'd5;

  typedef struct packed {
    logic                    opcode;
    logic [STYLE_W-1:0]      style_id;
    logic [FLAG_WIDTH-1:0]   flag_bits;
    logic [HANDLE_WIDTH-1:0] entry_handle;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic [HANDLE_WIDTH-1:0] found_handle;
    logic [6:0]              entry_index;
  } rsp_t;

  typedef struct packed {
    logic [STYLE_W-1:0]      style;
    logic [FLAG_WIDTH-1:0]   flags;
    logic [HANDLE_WIDTH-1:0] handle;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/sorted_style_flag_table.sv -----
`default_nettype none
// Operation: an insert scans for its place, shifts the entries above it up,
//   writes, then moves up the start pointers of later styles; a replace
//   rewrites in place; a lookup walks its style's run. One request at a time:
//   in_stall stays high until the response is taken (out_valid, no out_stall).
// Reset: count, style starts and style_count (to 32) clear; entries are not.
// ----------------------------------------------------------------------------
// sorted_style_flag_table
// Sorted entry table in one memory, with per-style run start pointers.
// ----------------------------------------------------------------------------
module sorted_style_flag_table (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [5:0]           cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ssft_pkg::req_t       in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ssft_pkg::rsp_t            out_data
);

  localparam int IW = ssft_pkg::IDX_W;
  localparam int CW = ssft_pkg::CNT_W;
  localparam int SW = ssft_pkg::STYLE_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCAN, S_DECIDE, S_SHRD, S_SHWR, S_WRITE, S_FIX,
    S_LRD, S_LSCAN, S_DEFRD, S_DEF, S_OUT, S_WAITO
  } state_t;

  state_t state;

  ssft_pkg::entry_t mem [ssft_pkg::CAPACITY];
  ssft_pkg::entry_t rd;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  ssft_pkg::entry_t mem_wdata;

  logic [CW-1:0]    start_q [ssft_pkg::MAX_STYLES];
  logic [CW-1:0]    count;
  logic [5:0]       style_count;
  ssft_pkg::req_t   req;
  logic [CW-1:0]    ptr;
  logic [CW-1:0]    pos;
  logic             hit;
  logic [IW-1:0]    best;
  logic [SW-1:0]    fix_s;
  logic             fix_done;
  logic [CW-1:0]    st;
  logic             st_ok;
  logic             repl;

  logic [6:0] limit;
  logic       bad;
  logic       lt_key, eq_key, subset;

  always_comb begin
    limit = (style_count > 6'(ssft_pkg::MAX_STYLES)) ? 7'(ssft_pkg::MAX_STYLES)
                                                     : {1'b0, style_count};
    bad    = {2'b0, in_data.style_id} >= limit;
    lt_key = (rd.style < req.style_id) ||
             (rd.style == req.style_id && rd.flags < req.flag_bits);
    eq_key = (rd.style == req.style_id) && (rd.flags == req.flag_bits);
    subset = (rd.flags & req.flag_bits) == rd.flags;
    st     = start_q[req.style_id];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd <= mem[mem_raddr];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr[IW-1:0];
    mem_wdata = rd;
    mem_raddr = ptr[IW-1:0];
    unique case (state)
      S_SHRD:  mem_raddr = IW'(ptr - 1'b1);
      S_SHWR:  begin mem_we = 1'b1; mem_waddr = ptr[IW-1:0]; mem_wdata = rd; end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = pos[IW-1:0];
        mem_wdata = '{style: req.style_id, flags: req.flag_bits,
                      handle: req.entry_handle};
      end
      S_DEFRD: mem_raddr = '0;
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      count       <= '0;
      style_count <= 6'd32;
      for (int i = 0; i < ssft_pkg::MAX_STYLES; i++) start_q[i] <= '0;
    end else begin
      if (cfg_we) style_count <= cfg_wdata;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          req <= in_data;
          st_ok <= 1'b0;
          if (bad) begin
            out_data <= '{status: ssft_pkg::ST_BADSTYLE, default: '0};
            state <= S_OUT;
          end else if (in_data.opcode == ssft_pkg::OP_INSERT) begin
            out_data <= '0;
            ptr <= '0;
            state <= S_SRD;
          end else begin
            out_data <= '0;
            ptr <= start_q[in_data.style_id];
            hit <= 1'b0;
            state <= S_LRD;
          end
        end
        S_SRD: state <= (ptr < count) ? S_SCAN : S_DECIDE;
        S_SCAN: begin
          if (ptr == st && rd.style == req.style_id) st_ok <= 1'b1;
          if (lt_key) begin
            ptr <= ptr + 1'b1;
            state <= S_SRD;
          end else state <= S_DECIDE;
        end
        S_DECIDE: begin
          pos <= ptr;
          repl <= (ptr < count) && eq_key;
          if (ptr < count && eq_key) begin
            state <= S_WRITE;
          end else if (count == CW'(ssft_pkg::CAPACITY)) begin
            out_data.status <= ssft_pkg::ST_FULL;
            state <= S_OUT;
          end else begin
            ptr <= count;
            state <= (count > ptr) ? S_SHRD : S_WRITE;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          ptr <= ptr - 1'b1;
          state <= (ptr - 1'b1 > pos) ? S_SHRD : S_WRITE;
        end
        S_WRITE: begin
          out_data.entry_index <= 7'(pos);
          if (repl) begin
            out_data.status <= ssft_pkg::ST_REPLACED;
            state <= S_OUT;
          end else begin
            out_data.status <= ssft_pkg::ST_INSERTED;
            ptr <= st;
            state <= S_FIX;
            fix_s <= req.style_id + 1'b1;
            fix_done <= 1'b0;
          end
        end
        S_FIX: begin
          if (!fix_done) begin
            // keep the start only if it already marks an entry of this style
            // at or below the insert position
            if (st > pos || st >= count || !st_ok)
              start_q[req.style_id] <= pos;
            fix_done <= 1'b1;
            if (SW'(req.style_id + 1'b1) == '0 ||
                7'(req.style_id) + 7'd1 >= limit) begin
              count <= count + 1'b1;
              state <= S_OUT;
            end
          end else begin
            start_q[fix_s] <= start_q[fix_s] + 1'b1;
            fix_s <= fix_s + 1'b1;
            if (7'(fix_s) + 7'd1 >= limit) begin
              count <= count + 1'b1;
              state <= S_OUT;
            end
          end
        end
        S_LRD: state <= (ptr < count) ? S_LSCAN : S_DEFRD;
        S_LSCAN: begin
          if (rd.style == req.style_id) begin
            if (subset) begin
              hit <= 1'b1;
              best <= ptr[IW-1:0];
              out_data.found_handle <= rd.handle;
            end
            ptr <= ptr + 1'b1;
            state <= S_LRD;
          end else state <= S_DEFRD;
        end
        S_DEFRD: begin
          if (hit) begin
            out_data.status <= ssft_pkg::ST_MATCH;
            out_data.entry_index <= 7'(best);
            state <= S_OUT;
          end else state <= S_DEF;
        end
        S_DEF: begin
          out_data.status <= ssft_pkg::ST_DEFAULT;
          out_data.found_handle <= (count != '0) ? rd.handle : '0;
          state <= S_OUT;
        end
        S_OUT: if (!out_valid) begin
          out_valid <= 1'b1;
          state <= S_WAITO;
        end
        S_WAITO: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ssft_pkg::CAPACITY)) else $error("count overflow");
  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !in_stall) else $error("stall while idle");
  a_grow: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + 1'b1))
    else $error("count step");
`endif

endmodule
`default_nettype wire
